// ===== hw/rtl/mnbs_pkg.sv =====
// Package for the multi-needle byte search: sizes, register slots and the
// structs passed between the window, match, emit and register-bank modules.
// Used by every other file of the block; depends on nothing.
package mnbs_pkg;

   localparam int PATTERN_COUNT      = 4;
   localparam int PATTERN_MAX_BYTES  = 8;
   localparam int OFFSET_BITS        = 32;

   localparam int BYTE_BITS          = 8;
   localparam int PATTERN_BITS       = 64;
   localparam int LENGTH_BITS        = 4;
   localparam int WHICH_BITS         = 2;
   localparam int RESULT_OFFSET_BITS = 32;
   localparam int CSR_INDEX_BITS     = 4;
   localparam int CSR_DATA_BITS      = 64;

   localparam int FILL_BITS  = (PATTERN_MAX_BYTES > 1) ? $clog2(PATTERN_MAX_BYTES) : 1;
   localparam int AVAIL_BITS = $clog2(PATTERN_MAX_BYTES + 1);
   localparam int CMP_BITS   = LENGTH_BITS + 1;

   // register map: two registers per needle, bytes first
   localparam int REGS_PER_PATTERN = 2;
   localparam int REG_BYTES_SLOT   = 0;
   localparam int REG_LENGTH_SLOT  = 1;

   typedef struct packed {
      logic [PATTERN_COUNT-1:0][PATTERN_BITS-1:0] pat_bytes;
      logic [PATTERN_COUNT-1:0][LENGTH_BITS-1:0]  pat_length;
   } cfg_type;

   typedef struct packed {
      logic [PATTERN_MAX_BYTES-1:0][BYTE_BITS-1:0] data;
      logic [AVAIL_BITS-1:0]                       avail;
      logic [OFFSET_BITS-1:0]                      base;
      logic                                        last;
   } job_type;

   typedef struct packed {
      logic [PATTERN_MAX_BYTES-1:0]                 mask;
      logic [PATTERN_MAX_BYTES-1:0][WHICH_BITS-1:0] which;
      logic [OFFSET_BITS-1:0]                       base;
      logic                                         last;
   } hits_type;

endpackage

// ===== hw/rtl/mnbs_ifs.sv =====
// Channel interfaces of the multi-needle byte search: stream bytes in,
// match results out, register writes. Depends on mnbs_pkg.
interface mnbs_req_if;
   logic                           valid;
   logic                           ready;
   logic [mnbs_pkg::BYTE_BITS-1:0] stream_byte;
   logic                           final_byte;
   modport source (output valid, stream_byte, final_byte, input ready);
   modport sink   (input valid, stream_byte, final_byte, output ready);
endinterface

interface mnbs_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    hit;
   logic [mnbs_pkg::WHICH_BITS-1:0]         which_pattern;
   logic [mnbs_pkg::RESULT_OFFSET_BITS-1:0] hit_offset;
   logic                                    scan_done;
   logic                                    run_end;
   modport source (output valid, hit, which_pattern, hit_offset, scan_done, run_end,
                   input ready);
   modport sink   (input valid, hit, which_pattern, hit_offset, scan_done, run_end,
                   output ready);
endinterface

interface mnbs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mnbs_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic [mnbs_pkg::CSR_DATA_BITS-1:0]  wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== hw/rtl/mnbs_csr.sv =====
// Needle register bank: bytes and length of each needle, written one word
// at a time. Depends on mnbs_pkg and mnbs_ifs.
module mnbs_csr (
   input  logic              clock,
   input  logic              reset,
   mnbs_csr_if.sink          csr_bus,
   output mnbs_pkg::cfg_type cfg
);

   mnbs_pkg::cfg_type cfg_ff;
   mnbs_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   // indexes beyond the map match no slot and drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         for (int i = 0; i < mnbs_pkg::PATTERN_COUNT; i++) begin
            if (csr_bus.reg_index == mnbs_pkg::CSR_INDEX_BITS'(
                   i * mnbs_pkg::REGS_PER_PATTERN + mnbs_pkg::REG_BYTES_SLOT)) begin
               cfg_in.pat_bytes[i] = csr_bus.wdata[mnbs_pkg::PATTERN_BITS-1:0];
            end
            if (csr_bus.reg_index == mnbs_pkg::CSR_INDEX_BITS'(
                   i * mnbs_pkg::REGS_PER_PATTERN + mnbs_pkg::REG_LENGTH_SLOT)) begin
               cfg_in.pat_length[i] = csr_bus.wdata[mnbs_pkg::LENGTH_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/mnbs_window.sv =====
// Input side: byte window, fill count and stream position, and the job
// register that hands each byte with its window to matching.
// Depends on mnbs_pkg and mnbs_ifs.
module mnbs_window (
   input  logic              clock,
   input  logic              reset,
   mnbs_req_if.sink          req_bus,
   input  logic              job_taken,
   output logic              job_valid,
   output mnbs_pkg::job_type job
);

   localparam int MaxB = mnbs_pkg::PATTERN_MAX_BYTES;

   logic [MaxB-1:0][mnbs_pkg::BYTE_BITS-1:0] window_ff, window_in;
   logic [mnbs_pkg::FILL_BITS-1:0]           fill_ff, fill_in;
   logic [mnbs_pkg::OFFSET_BITS-1:0]         pos_ff, pos_in;
   logic                                     job_valid_ff, job_valid_in;
   mnbs_pkg::job_type                        job_ff, job_in;

   logic                                     accept;
   logic                                     full;
   logic [MaxB-1:0][mnbs_pkg::BYTE_BITS-1:0] merged;

   assign req_bus.ready = !job_valid_ff || job_taken;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (fill_ff == mnbs_pkg::FILL_BITS'(MaxB - 1));
   assign job_valid     = job_valid_ff;
   assign job           = job_ff;

   always_comb begin
      // window bytes followed by the new byte at the fill point
      for (int i = 0; i < MaxB; i++) begin
         merged[i] = (mnbs_pkg::FILL_BITS'(i) == fill_ff) ? req_bus.stream_byte
                                                          : window_ff[i];
      end

      window_in = window_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      if (accept) begin
         if (req_bus.final_byte) begin
            window_in = '0;
            fill_in   = '0;
            pos_in    = '0;
         end else if (full) begin
            // oldest offset is tested now: shift it out
            for (int i = 0; i < MaxB - 1; i++) begin
               window_in[i] = merged[i+1];
            end
            pos_in = pos_ff + 1'b1;
         end else begin
            window_in = merged;
            fill_in   = fill_ff + 1'b1;
            pos_in    = pos_ff + 1'b1;
         end
      end

      job_in.data  = merged;
      job_in.avail = mnbs_pkg::AVAIL_BITS'(fill_ff) + 1'b1;
      job_in.base  = pos_ff - mnbs_pkg::OFFSET_BITS'(fill_ff);
      job_in.last  = req_bus.final_byte;

      if (accept) begin
         job_valid_in = 1'b1;
      end else if (job_taken) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.final_byte |=> fill_ff == '0 && pos_ff == '0)
      else $error("stream state not cleared after final byte");

   a_full_stays: assert property (@(posedge clock) disable iff (reset)
      accept && !req_bus.final_byte && full |=> full)
      else $error("full window lost a byte");

endmodule

// ===== hw/rtl/mnbs_match.sv =====
// Needle compare: for every tested offset of a job, the first needle in priority
// order that fits and matches. Pure logic. Depends on mnbs_pkg.
module mnbs_match (
   input  mnbs_pkg::cfg_type  cfg,
   input  mnbs_pkg::job_type  job,
   output mnbs_pkg::hits_type hits
);

   localparam int MaxB = mnbs_pkg::PATTERN_MAX_BYTES;

   always_comb begin
      logic                             found;
      logic                             test;
      logic                             fits;
      logic                             eq;
      logic [mnbs_pkg::CMP_BITS-1:0]    len_ext;
      logic [mnbs_pkg::CMP_BITS-1:0]    room;

      hits.base = job.base;
      hits.last = job.last;
      for (int k = 0; k < MaxB; k++) begin
         hits.mask[k]  = 1'b0;
         hits.which[k] = '0;
         found = 1'b0;
         // a mid-stream byte tests only the oldest offset of a full window
         if (job.last) begin
            test = (mnbs_pkg::AVAIL_BITS'(k) < job.avail);
         end else begin
            test = (k == 0) && (job.avail == mnbs_pkg::AVAIL_BITS'(MaxB));
         end
         room = mnbs_pkg::CMP_BITS'(job.avail) - mnbs_pkg::CMP_BITS'(k);
         for (int i = 0; i < mnbs_pkg::PATTERN_COUNT; i++) begin
            len_ext = mnbs_pkg::CMP_BITS'(cfg.pat_length[i]);
            fits    = (len_ext <= mnbs_pkg::CMP_BITS'(MaxB)) && (len_ext <= room);
            eq      = 1'b1;
            for (int j = 0; j < MaxB; j++) begin
               if (k + j < MaxB) begin
                  if (mnbs_pkg::CMP_BITS'(j) < len_ext &&
                      cfg.pat_bytes[i][mnbs_pkg::BYTE_BITS*j +: mnbs_pkg::BYTE_BITS]
                         != job.data[k+j]) begin
                     eq = 1'b0;
                  end
               end
            end
            if (test && fits && eq && !found) begin
               found         = 1'b1;
               hits.mask[k]  = 1'b1;
               hits.which[k] = mnbs_pkg::WHICH_BITS'(i);
            end
         end
      end
   end

endmodule

// ===== hw/rtl/mnbs_emit.sv =====
// Result side: hit register that holds one job's matches, and the output
// register that sends them one word a cycle when not stalled, oldest offset
// first, then the closing word after a final byte. Depends on mnbs_pkg and mnbs_ifs.
module mnbs_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  mnbs_pkg::hits_type hits,
   output logic               job_taken,
   mnbs_rsp_if.source         rsp_bus
);

   localparam int MaxB = mnbs_pkg::PATTERN_MAX_BYTES;

   logic                                      b_valid_ff, b_valid_in;
   mnbs_pkg::hits_type                        b_ff, b_in;
   logic                                      out_valid_ff, out_valid_in;
   logic                                      hit_ff;
   logic [mnbs_pkg::WHICH_BITS-1:0]           which_ff;
   logic [mnbs_pkg::RESULT_OFFSET_BITS-1:0]   offset_ff;
   logic                                      done_ff;
   logic                                      end_ff;

   logic                                      out_free;
   logic                                      any;
   logic                                      emit;
   logic                                      b_last;
   logic                                      b_take;
   logic                                      produces;
   logic                                      sel_found;
   logic [mnbs_pkg::FILL_BITS-1:0]            sel;
   logic [MaxB-1:0]                           mask_rest;
   logic [mnbs_pkg::OFFSET_BITS-1:0]          sel_offset;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign any       = |b_ff.mask;
   assign emit      = b_valid_ff && out_free;
   assign mask_rest = b_ff.mask & (b_ff.mask - 1'b1);
   assign b_last    = any ? (mask_rest == '0 && !b_ff.last) : 1'b1;
   assign b_take    = !b_valid_ff || (emit && b_last);
   assign produces  = (|hits.mask) || hits.last;
   // a job with nothing to report drops at once
   assign job_taken = job_valid && (!produces || b_take);

   always_comb begin
      sel_found = 1'b0;
      sel       = '0;
      for (int k = 0; k < MaxB; k++) begin
         if (!sel_found && b_ff.mask[k]) begin
            sel_found = 1'b1;
            sel       = mnbs_pkg::FILL_BITS'(k);
         end
      end
      sel_offset = b_ff.base + mnbs_pkg::OFFSET_BITS'(sel);

      b_in       = b_ff;
      b_valid_in = b_valid_ff;
      if (job_valid && produces && b_take) begin
         b_in       = hits;
         b_valid_in = 1'b1;
      end else if (emit) begin
         b_in.mask  = mask_rest;
         b_valid_in = !b_last;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
      if (emit) begin
         hit_ff    <= any;
         which_ff  <= any ? b_ff.which[sel] : '0;
         offset_ff <= any ? mnbs_pkg::RESULT_OFFSET_BITS'(sel_offset) : '0;
         done_ff   <= !any;
         end_ff    <= any ? !b_ff.last : 1'b1;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.hit           = hit_ff;
   assign rsp_bus.which_pattern = which_ff;
   assign rsp_bus.hit_offset    = offset_ff;
   assign rsp_bus.scan_done     = done_ff;
   assign rsp_bus.run_end       = end_ff;

   a_hold_has_work: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (|b_ff.mask) || b_ff.last)
      else $error("hit register held with nothing to send");

   a_close_word: assert property (@(posedge clock) disable iff (reset)
      emit && !any |=> out_valid_ff && done_ff && end_ff && !hit_ff)
      else $error("closing word malformed");

endmodule

// ===== hw/rtl/multi_needle_byte_search.sv =====
// Multi-needle byte search. A taken byte passes the job register, then the hit
// register, then the output register; back-pressure can hold it at each one.
// One byte a cycle while nothing stalls; a final byte holds its results in the
// hit register and sends one word per ready cycle (up to nine), stalling input while more than one remains.
// Synchronous active-high reset clears needles, window, position and all valids.
module multi_needle_byte_search (
   input  logic        clock,
   input  logic        reset,
   mnbs_req_if.sink    req_bus,
   mnbs_rsp_if.source  rsp_bus,
   mnbs_csr_if.sink    csr_bus
);

   mnbs_pkg::cfg_type  cfg;
   mnbs_pkg::job_type  job;
   mnbs_pkg::hits_type hits;
   logic               job_valid;
   logic               job_taken;

   // needle registers, to be written only while the block is idle; the block does not enforce it
   mnbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // hold the last bytes and the position; register each byte with its window
   mnbs_window u_window (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .job_taken (job_taken),
      .job_valid (job_valid),
      .job       (job)
   );

   // test every needle at every pending offset in parallel
   mnbs_match u_match (
      .cfg  (cfg),
      .job  (job),
      .hits (hits)
   );

   // register the hits and send them one word at a time
   mnbs_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .hits      (hits),
      .job_taken (job_taken),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== sim/tb_multi_needle_byte_search.sv =====
// Self-checking bench for multi_needle_byte_search: streams bytes through the
// search, predicts every match and closing word, and checks them in order.
// Depends on mnbs_pkg and the channel interfaces in mnbs_ifs.sv.
module tb_multi_needle_byte_search;
   timeunit 1ns;
   timeprecision 1ps;

   import mnbs_pkg::*;

   localparam int CLOCK_PERIOD   = 4;
   localparam int RESET_CYCLES   = 5;
   localparam int DRAIN_CYCLES   = 12;
   localparam int LIMIT_CYCLES   = 400_000;
   localparam int STREAM_TARGET  = 280;
   localparam int HOLD_CYCLES    = 90;
   localparam int MAX_GAP        = 17;
   localparam int REG_COUNT      = PATTERN_COUNT * REGS_PER_PATTERN;
   localparam int REG_INDEX_TOP  = (1 << CSR_INDEX_BITS) - 1;

   typedef struct packed {
      logic [BYTE_BITS-1:0] value;
      logic                 last;
   } stream_word_type;

   typedef struct packed {
      logic                          hit;
      logic [WHICH_BITS-1:0]         which;
      logic [RESULT_OFFSET_BITS-1:0] offset;
      logic                          done;
      logic                          run_end;
   } search_report_type;

   logic clock = 1'b0;
   logic reset;

   mnbs_req_if req_bus ();
   mnbs_rsp_if rsp_bus ();
   mnbs_csr_if csr_bus ();

   multi_needle_byte_search dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Shadow of the search: needles as last written, the unchecked tail of the
   // stream and the offset of the next byte.
   logic [PATTERN_BITS-1:0] needle_bytes [PATTERN_COUNT];
   logic [LENGTH_BITS-1:0]  needle_len   [PATTERN_COUNT];
   logic [BYTE_BITS-1:0]    tail_bytes   [PATTERN_MAX_BYTES-1];
   logic [OFFSET_BITS-1:0]  stream_pos;
   int                      tail_count;

   stream_word_type   stream_queue [$];   // bytes waiting to be offered
   search_report_type due_reports  [$];   // words the search still owes us

   int  fail_count;
   int  cycle_count;
   bit  sender_calm;
   bit  receiver_calm;
   bit  squeeze_armed;
   logic rsp_hold;
   int  req_gap;
   int  rsp_stall;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic void store_needle_reg(input int idx, input logic [CSR_DATA_BITS-1:0] data);
      // indexes past the last needle register fall on nothing
      if (idx < REG_COUNT) begin
         if (idx % REGS_PER_PATTERN == REG_BYTES_SLOT)
            needle_bytes[idx / REGS_PER_PATTERN] = data;
         else
            needle_len[idx / REGS_PER_PATTERN] = data[LENGTH_BITS-1:0];
      end
   endfunction

   // First needle, in priority order, that fits in what is left of the
   // stream from offset k and matches byte for byte there; -1 if none.
   function automatic int first_needle(input logic [PATTERN_MAX_BYTES-1:0][BYTE_BITS-1:0] seg,
                                       input int k, input int avail);
      for (int i = 0; i < PATTERN_COUNT; i++) begin
         int len;
         bit same;
         len  = needle_len[i];
         same = 1'b1;
         if (len > PATTERN_MAX_BYTES || len > avail - k)
            continue;
         for (int j = 0; j < len; j++)
            if (needle_bytes[i][BYTE_BITS*j +: BYTE_BITS] != seg[k + j])
               same = 1'b0;
         if (same)
            return i;
      end
      return -1;
   endfunction

   function automatic void search_byte(input logic [BYTE_BITS-1:0] value, input logic last);
      logic [PATTERN_MAX_BYTES-1:0][BYTE_BITS-1:0] seg;
      logic [OFFSET_BITS-1:0] base;
      int avail;
      int w;
      seg = '0;
      for (int k = 0; k < tail_count; k++)
         seg[k] = tail_bytes[k];
      seg[tail_count] = value;
      avail = tail_count + 1;
      base  = stream_pos - OFFSET_BITS'(tail_count);
      if (!last) begin
         // a full window settles its oldest offset and slides by one byte
         if (avail == PATTERN_MAX_BYTES) begin
            w = first_needle(seg, 0, avail);
            if (w >= 0)
               due_reports.push_back('{1'b1, WHICH_BITS'(w), base[RESULT_OFFSET_BITS-1:0],
                                       1'b0, 1'b1});
            for (int k = 0; k < PATTERN_MAX_BYTES - 1; k++)
               tail_bytes[k] = seg[k + 1];
            tail_count = PATTERN_MAX_BYTES - 1;
         end else begin
            tail_bytes[tail_count] = value;
            tail_count = avail;
         end
         stream_pos = stream_pos + 1'b1;
      end else begin
         // flush every pending offset oldest first, then close the stream
         for (int k = 0; k < avail; k++) begin
            logic [OFFSET_BITS-1:0] at;
            at = base + OFFSET_BITS'(k);
            w  = first_needle(seg, k, avail);
            if (w >= 0)
               due_reports.push_back('{1'b1, WHICH_BITS'(w), at[RESULT_OFFSET_BITS-1:0],
                                       1'b0, 1'b0});
         end
         due_reports.push_back('{1'b0, '0, '0, 1'b1, 1'b1});
         for (int k = 0; k < PATTERN_MAX_BYTES - 1; k++)
            tail_bytes[k] = '0;
         tail_count = 0;
         stream_pos = '0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Idling and stimulus helpers
   // ---------------------------------------------------------------------

   // Wait before the next word: none in calm phases, else mostly short.
   function automatic int draw_gap(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 9);
      if (r < 4)
         return 0;
      if (r < 8)
         return $urandom_range(1, 4);
      return $urandom_range(5, MAX_GAP);
   endfunction

   // Small alphabet so that random needles and random bytes meet often.
   function automatic logic [BYTE_BITS-1:0] alphabet_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h40 + BYTE_BITS'($urandom_range(0, 2));
         default: return BYTE_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [BYTE_BITS-1:0] pick_byte(input bit noisy);
      int n;
      int j;
      if (noisy || $urandom_range(0, 1) == 0)
         return noisy ? BYTE_BITS'($urandom_range(0, 255)) : alphabet_byte();
      n = $urandom_range(0, PATTERN_COUNT - 1);
      j = $urandom_range(0, PATTERN_MAX_BYTES - 1);
      return needle_bytes[n][BYTE_BITS*j +: BYTE_BITS];
   endfunction

   function automatic void push_word(input logic [BYTE_BITS-1:0] value, input logic last);
      stream_queue.push_back('{value, last});
   endfunction

   // One stream of the given length ending on a final byte. Well-formed
   // streams plant needle copies, now and then cut short; noisy ones are
   // plain random bytes.
   function automatic void queue_stream(input int span, input bit noisy);
      int k;
      int n;
      int cut;
      k = 0;
      while (k < span) begin
         if (!noisy && $urandom_range(0, 2) != 0) begin
            n   = $urandom_range(0, PATTERN_COUNT - 1);
            cut = (needle_len[n] > PATTERN_MAX_BYTES) ? PATTERN_MAX_BYTES : needle_len[n];
            if ($urandom_range(0, 4) == 0)
               cut = $urandom_range(0, cut);
            for (int j = 0; j < cut && k < span; j++) begin
               push_word(needle_bytes[n][BYTE_BITS*j +: BYTE_BITS], k == span - 1);
               k++;
            end
         end else begin
            push_word(pick_byte(noisy), k == span - 1);
            k++;
         end
      end
   endfunction

   // One register write; valid is left high so that writes can run back to back.
   task automatic write_reg(input int idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= CSR_INDEX_BITS'(idx);
      csr_bus.wdata     <= data;
      do @(posedge clock); while (!csr_bus.ready);
      store_needle_reg(idx, data);
   endtask

   // Write the needles, all of them or a random subset, with random gaps
   // between words. Length words sometimes carry junk above the length field.
   task automatic program_needles(input logic [PATTERN_COUNT-1:0][PATTERN_BITS-1:0] pats,
                                  input logic [PATTERN_COUNT-1:0][LENGTH_BITS-1:0] lens,
                                  input bit every);
      logic [CSR_DATA_BITS-1:0] data;
      bit started;
      started = 1'b0;
      for (int idx = 0; idx < REG_COUNT; idx++) begin
         if (!every && $urandom_range(0, 1) == 0)
            continue;
         if (idx % REGS_PER_PATTERN == REG_BYTES_SLOT) begin
            data = pats[idx / REGS_PER_PATTERN];
         end else begin
            data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
            data[LENGTH_BITS-1:0] = lens[idx / REGS_PER_PATTERN];
         end
         if (started && $urandom_range(0, 2) == 0) begin
            csr_bus.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         end
         write_reg(idx, data);
         started = 1'b1;
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Hold until every byte is taken and every owed word has come back, then
   // let the pipeline run dry before anyone touches the registers.
   task automatic finish_phase();
      while (stream_queue.size() != 0 || due_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Byte driver: offer the queue head, hold it until taken, predict on
   // acceptance, then draw the wait before the next word.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic fire;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         fire = req_bus.valid && req_bus.ready;
         if (fire) begin
            search_byte(req_bus.stream_byte, req_bus.final_byte);
            void'(stream_queue.pop_front());
            req_gap = draw_gap(sender_calm);
         end
         if (req_bus.valid && !fire) begin
            // hold: the word stays on the bus until it is taken
         end else if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (stream_queue.size() != 0) begin
            req_bus.valid       <= 1'b1;
            req_bus.stream_byte <= stream_queue[0].value;
            req_bus.final_byte  <= stream_queue[0].last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: compare each accepted word with the oldest prediction.
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      search_report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_reports.size() == 0) begin
               $error("result word with nothing expected: hit %0b offset %0h done %0b",
                      rsp_bus.hit, rsp_bus.hit_offset, rsp_bus.scan_done);
               fail_count++;
            end else begin
               want = due_reports.pop_front();
               check_field("hit",           want.hit,     rsp_bus.hit);
               check_field("which_pattern", want.which,   rsp_bus.which_pattern);
               check_field("hit_offset",    want.offset,  rsp_bus.hit_offset);
               check_field("scan_done",     want.done,    rsp_bus.scan_done);
               check_field("run_end",       want.run_end, rsp_bus.run_end);
            end
            rsp_stall = draw_gap(receiver_calm);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_bus.ready <= (rsp_stall == 0) && !rsp_hold;
      end
   end

   // Long back-pressure: once armed, keep the receiver shut while the sender
   // keeps pushing, so the search backs up.
   initial begin
      rsp_hold = 1'b0;
      wait (squeeze_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin
      logic [PATTERN_COUNT-1:0][PATTERN_BITS-1:0] pats;
      logic [PATTERN_COUNT-1:0][LENGTH_BITS-1:0]  lens;
      int streamed;
      int phase;
      int phase_words;
      int span;
      int r;

      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.stream_byte = '0;
      req_bus.final_byte  = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.reg_index   = '0;
      csr_bus.wdata       = '0;
      fail_count    = 0;
      cycle_count   = 0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      squeeze_armed = 1'b0;
      req_gap       = 0;
      rsp_stall     = 0;
      stream_pos    = '0;
      tail_count    = 0;
      for (int i = 0; i < PATTERN_COUNT; i++) begin
         needle_bytes[i] = '0;
         needle_len[i]   = '0;
      end
      for (int k = 0; k < PATTERN_MAX_BYTES - 1; k++)
         tail_bytes[k] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Needles straight out of reset are all empty, so needle 0 must claim
      // every offset of this stream.
      @(negedge clock);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'h5A, 1'b0);
      push_word(8'hA5, 1'b1);
      finish_phase();

      // Directed needles: a full eight-byte needle, one too long to ever
      // match, a two-byte needle and an empty one that catches everything
      // the others miss. Also poke an index past the map.
      write_reg(REG_COUNT + $urandom_range(0, REG_INDEX_TOP - REG_COUNT), {$urandom, $urandom});
      pats[0] = 64'h80_05_04_03_02_01_FF_00;
      lens[0] = 4'd8;
      pats[1] = 64'h80_05_04_03_02_01_FF_00;
      lens[1] = 4'd9;
      pats[2] = 64'h00_00_00_00_00_00_FF_00;
      lens[2] = 4'd2;
      pats[3] = '1;
      lens[3] = 4'd0;
      program_needles(pats, lens, 1'b1);
      @(negedge clock);
      for (int j = 0; j < PATTERN_MAX_BYTES; j++)
         push_word(pats[0][BYTE_BITS*j +: BYTE_BITS], 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b1);
      // a lone final byte: only the empty needle fits
      push_word(8'h00, 1'b1);
      // two-byte needle at the stream start, then a final offset too short for it
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'h00, 1'b1);
      finish_phase();

      // Random phases, each with its own needles and idling pattern.
      streamed = 0;
      phase    = 0;
      while (streamed < STREAM_TARGET) begin
         case (phase % 5)
            1: begin
               pats = '1;
               lens[0] = 4'd8;
               lens[1] = 4'd15;
               lens[2] = 4'd1;
               lens[3] = 4'd8;
            end
            3: begin
               pats = '0;
               for (int n = 0; n < PATTERN_COUNT; n++)
                  lens[n] = 4'd8;
            end
            default: begin
               for (int n = 0; n < PATTERN_COUNT; n++) begin
                  for (int j = 0; j < PATTERN_MAX_BYTES; j++)
                     pats[n][BYTE_BITS*j +: BYTE_BITS] = alphabet_byte();
                  r = $urandom_range(0, 9);
                  lens[n] = (r == 0) ? 4'd0 :
                            (r == 1) ? LENGTH_BITS'($urandom_range(9, 15)) :
                                       LENGTH_BITS'($urandom_range(1, 8));
               end
            end
         endcase
         if ($urandom_range(0, 7) == 0)
            write_reg(REG_COUNT + $urandom_range(0, REG_INDEX_TOP - REG_COUNT),
                      {$urandom, $urandom});
         program_needles(pats, lens, phase < 2 || phase % 5 != 0 && phase % 5 != 2);

         @(negedge clock);
         sender_calm   = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);
         phase_words   = 0;
         while (phase_words < 30) begin
            span = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            queue_stream(span, $urandom_range(0, 4) == 0);
            phase_words += span;
         end
         streamed += phase_words;
         finish_phase();
         phase++;
      end

      // Back-pressure: the empty needle matches every offset, so every offset
      // owes a word while the receiver is shut and the sender never pauses.
      pats[0] = {$urandom, $urandom};
      lens[0] = 4'd0;
      program_needles(pats, lens, 1'b1);
      @(negedge clock);
      sender_calm   = 1'b1;
      receiver_calm = 1'b1;
      squeeze_armed = 1'b1;
      for (int k = 0; k < 40; k++)
         push_word(BYTE_BITS'($urandom_range(0, 255)), k == 39);
      finish_phase();

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/mnbs_pkg.sv
hw/rtl/mnbs_ifs.sv
hw/rtl/mnbs_csr.sv
hw/rtl/mnbs_window.sv
hw/rtl/mnbs_match.sv
hw/rtl/mnbs_emit.sv
hw/rtl/multi_needle_byte_search.sv
sim/tb_multi_needle_byte_search.sv
